[rtl/sstf_pkg.sv]
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants of the shortest-seek-first request scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_COLLECT,   // queueing requests of a batch
        ST_SCAN,      // sweeping the queue for the nearest pending request
        ST_EMIT       // handing one result over, marking the entry served
    } t_state;

    // fixed field widths of the stream ports
    localparam int FIELD_CYL_BITS  = 16;
    localparam int FIELD_SUM_BITS  = 22;
    localparam int IN_TDATA_BITS   = 16;
    localparam int OUT_TDATA_BITS  = 56;
    localparam int CFG_DATA_BITS   = 16;

    // saturation limit of the running movement sum
    localparam logic [FIELD_SUM_BITS-1:0] SUM_MAX = {FIELD_SUM_BITS{1'b1}};

endpackage

[rtl/sstf_ram.sv]
// ----------------------------------------------------------------------------
// sstf_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sstf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sstf_disk_request_scheduler.sv]
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler
// Queues a batch of cylinder requests and serves them nearest-first.
// ----------------------------------------------------------------------------
// requests: one per cycle while collecting; after the last request each result
//   is found by a sweep of the request RAM through its single read port and
//   handed over in an emit state; no request is taken until the batch drains
// reset: synchronous active low; queue, sums and flags empty, start cylinder 0;
//   the RAM needs no clearing pass since only entries below the fill count
//   are read
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 64,
    parameter int CYLINDER_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write channel: start cylinder
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // request stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [15:0] request_cylinder
    input  logic                      s_axis_tlast,   // last_request
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [15:0] served_cylinder, [31:16] seek_distance, [53:32] total_movement,
    // [54] overflow, [55] zero
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    output logic                      m_axis_tlast    // last_served
);

    localparam int CB = CYLINDER_BITS;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = CYLINDER_BITS + 1;   // entry: served bit over cylinder

    // control state
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count;       // requests queued in this batch
    logic [CW-1:0]        r_remaining;   // requests still pending
    logic                 r_dropped;
    logic [CFG_DATA_BITS-1:0] r_start;

    // scan state
    logic [CW-1:0]        r_rd_idx;      // next address to read
    logic                 r_rd_vld;      // read data valid this cycle
    logic                 r_rd_last;     // read data is the last entry
    logic [AW-1:0]        r_cmp_idx;     // address of the read data
    logic                 r_have_best;
    logic [AW-1:0]        r_best_idx;
    logic [CB-1:0]        r_best_cyl;
    logic [CB-1:0]        r_best_d;

    // head and running sum
    logic [CB-1:0]        r_head;
    logic [FIELD_SUM_BITS-1:0] r_sum;

    // output register
    logic                 r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;
    logic                 r_out_last;

    // ram ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [RW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [RW-1:0]        ram_rdata;

    // strobes
    logic                 in_xfer;
    logic                 queue_full;
    logic                 out_free;
    logic                 out_load;
    logic                 scan_done;
    logic                 batch_done;
    logic [CW-1:0]        count_after;

    // cylinder width adaptation
    logic [31:0]          in_cyl_w;
    logic [31:0]          start_w;
    logic [CB-1:0]        in_cyl;
    logic [CB-1:0]        start_cyl;

    // compare path
    logic                 rd_served;
    logic [CB-1:0]        rd_cyl;
    logic [CB-1:0]        rd_d;
    logic                 take_rd;

    // result assembly
    logic [32:0]          sum_wide;
    logic [FIELD_SUM_BITS-1:0] sum_sat;
    logic [31:0]          best_cyl_w;
    logic [31:0]          best_d_w;

    assign in_cyl_w  = {16'b0, s_axis_tdata[FIELD_CYL_BITS-1:0]};
    assign start_w   = {16'b0, r_start};
    assign in_cyl    = in_cyl_w[CB-1:0];
    assign start_cyl = start_w[CB-1:0];

    assign o_cfg_ready = 1'b1;

    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign queue_full  = (r_count >= CW'(QUEUE_DEPTH));
    assign count_after = queue_full ? r_count : CW'(r_count + 1'b1);
    assign out_free    = !r_out_valid || m_axis_tready;

    // distance of the entry just read from the head
    assign rd_served = ram_rdata[CB];
    assign rd_cyl    = ram_rdata[CB-1:0];
    assign rd_d      = (rd_cyl > r_head) ? (rd_cyl - r_head) : (r_head - rd_cyl);
    // strict less keeps the earliest entry on a tie
    assign take_rd   = r_rd_vld && !rd_served && (!r_have_best || (rd_d < r_best_d));
    assign scan_done = r_rd_vld && r_rd_last;

    // saturating running sum
    assign sum_wide   = 33'(r_sum) + 33'(r_best_d);
    assign sum_sat    = (sum_wide > 33'(SUM_MAX)) ? SUM_MAX : sum_wide[FIELD_SUM_BITS-1:0];
    assign best_cyl_w = 32'(r_best_cyl);
    assign best_d_w   = 32'(r_best_d);
    assign batch_done = (r_remaining == CW'(1));

    // fsm outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_count[AW-1:0];
        ram_wdata     = {1'b0, in_cyl};
        ram_re        = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                s_axis_tready = 1'b1;
                ram_we        = in_xfer && !queue_full;
            end
            ST_SCAN: begin
                ram_re = (r_rd_idx < r_count);
            end
            ST_EMIT: begin
                out_load  = out_free;
                // retire the picked entry
                ram_we    = out_free;
                ram_waddr = r_best_idx;
                ram_wdata = {1'b1, r_best_cyl};
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // fsm next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (in_xfer && s_axis_tlast && (count_after != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_state = batch_done ? ST_COLLECT : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start <= i_cfg_data;
        end
    end

    // queue bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_remaining <= '0;
            r_dropped   <= 1'b0;
            r_sum       <= '0;
            r_head      <= '0;
        end else begin
            if (r_state == ST_COLLECT && in_xfer) begin
                r_count <= count_after;
                if (queue_full) begin
                    r_dropped <= 1'b1;
                end
                if (s_axis_tlast) begin
                    r_head      <= start_cyl;
                    r_sum       <= '0;
                    r_remaining <= count_after;
                    // empty batch: nothing to serve, start over
                    if (count_after == '0) begin
                        r_dropped <= 1'b0;
                    end
                end
            end
            if (r_state == ST_EMIT && out_load) begin
                r_head      <= r_best_cyl;
                r_remaining <= CW'(r_remaining - 1'b1);
                if (batch_done) begin
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                    r_sum     <= '0;
                end else begin
                    r_sum <= sum_sat;
                end
            end
        end
    end

    // queue sweep and nearest-entry tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            r_rd_vld <= ram_re;
            if (ram_re) begin
                r_cmp_idx <= r_rd_idx[AW-1:0];
                r_rd_last <= (CW'(r_rd_idx + 1'b1) == r_count);
                r_rd_idx  <= CW'(r_rd_idx + 1'b1);
            end
            if (take_rd) begin
                r_have_best <= 1'b1;
                r_best_idx  <= r_cmp_idx;
                r_best_cyl  <= rd_cyl;
                r_best_d    <= rd_d;
            end
            // new sweep starts after each pick and at the end of a batch
            if ((r_state == ST_EMIT && out_load) || r_state == ST_COLLECT) begin
                r_rd_idx    <= '0;
                r_have_best <= 1'b0;
            end
        end
    end

    // output register, refilled in the cycle the previous result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {1'b0, r_dropped, sum_sat,
                           best_d_w[FIELD_CYL_BITS-1:0], best_cyl_w[FIELD_CYL_BITS-1:0]};
            r_out_last <= batch_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // request store with per-entry served bit
    sstf_ram #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // a sweep only runs while some request is still pending
    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_remaining != '0))
        else $error("scan with no pending request");

    // every emitted result comes from an entry the sweep found pending
    a_emit_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_have_best)
        else $error("emit without a picked entry");

    // fill count never exceeds the queue
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("request count beyond queue depth");

    // the final result of a batch empties the queue and reopens the input
    a_batch_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && batch_done) |=> (r_state == ST_COLLECT && r_count == '0
                                      && !r_dropped && m_axis_tlast))
        else $error("batch not closed after final result");

endmodule
